// ----- rtl/pida_pkg.sv -----
package pida_pkg;

  localparam int DEPTH     = 64;
  localparam int ELEM_W    = 32;
  localparam int POS_W     = 7;
  localparam int CNT_OUT_W = 7;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int GROUP     = 8;
  localparam int NGROUP    = (DEPTH + GROUP - 1) / GROUP;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BADPOS = 2'd1,
    STS_EMPTY  = 2'd2,
    STS_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_GATHER,
    PH_DONE
  } phase_t;

  // Shift command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  idx;
    logic [ELEM_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- rtl/pida_cell.sv -----
module pida_cell
  import pida_pkg::*;
(
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  my_idx,
  input  logic [ELEM_W-1:0] left_data,
  input  logic [ELEM_W-1:0] right_data,
  output logic [ELEM_W-1:0] data
);

  // Insert: take the new value at the target, shift up above it.
  // Delete: shift down from the target onwards.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (my_idx == cmd.idx) begin
        data <= cmd.value;
      end else if (my_idx > cmd.idx) begin
        data <= left_data;
      end
    end else if (cmd.del) begin
      if (my_idx >= cmd.idx) begin
        data <= right_data;
      end
    end
  end

endmodule

// ----- rtl/pida_reduce.sv -----
module pida_reduce
  import pida_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [IDX_W-1:0]  idx,
  input  logic [ELEM_W-1:0] data [DEPTH],
  output logic [ELEM_W-1:0] groups [NGROUP]
);

  logic [ELEM_W-1:0] groups_next [NGROUP];

  // Mask every cell but the addressed one, OR within each group
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      groups_next[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          if (idx == IDX_W'(g * GROUP + k)) begin
            groups_next[g] = groups_next[g] | data[g * GROUP + k];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      groups <= groups_next;
    end
  end

endmodule

// ----- rtl/positional_insert_delete_array_top.sv -----
// A request accepted from idle or done passes through the gather phase to the done phase, where done marks its result.
// A new request can be taken while the last result is out in the done phase; busy is high for the single gather cycle.
// The gather cycle is the registered OR tree that picks the addressed cell's element.
// Reset (rst, synchronous) empties the list and idles the pipeline; cell contents are kept.
// Results cannot be held off: done is high for exactly one cycle.
module positional_insert_delete_array_top
  import pida_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               req_type,
  input  logic [POS_W-1:0]         position,
  input  logic signed [ELEM_W-1:0] value,
  output logic                     done,
  output logic [1:0]               status,
  output logic signed [ELEM_W-1:0] element,
  output logic [CNT_OUT_W-1:0]     count
);

  phase_t phase, phase_next;
  logic   accept;

  // List length and the registered result fields
  logic [CNT_W-1:0]  elem_count, elem_count_next;
  status_t           sts, sts_next;
  logic              want, want_next;
  logic [ELEM_W-1:0] elem_q, elem_q_next;

  // Wide copies for the position checks
  logic [CMP_W-1:0] pos_ext, cnt_ext, pos_m1;
  logic             pos_zero, ins_bad, rd_bad, is_empty, is_full;
  req_t             kind;

  cell_cmd_t         cmd;
  logic [ELEM_W-1:0] cells [DEPTH];
  logic [ELEM_W-1:0] groups [NGROUP];

  assign accept   = start && !busy;
  assign kind     = req_t'(req_type);
  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(elem_count);
  assign pos_m1   = pos_ext - CMP_W'(1);
  assign pos_zero = (pos_ext == '0);
  assign ins_bad  = pos_zero || (pos_ext > cnt_ext + CMP_W'(1));
  assign rd_bad   = pos_zero || (pos_ext > cnt_ext);
  assign is_empty = (cnt_ext == '0);
  assign is_full  = (cnt_ext == CMP_W'(DEPTH));

  // Decode the request: status, new length and the shift command
  always_comb begin
    sts_next        = STS_OK;
    want_next       = 1'b0;
    elem_count_next = elem_count;
    cmd.ins         = 1'b0;
    cmd.del         = 1'b0;
    cmd.idx         = pos_m1[IDX_W-1:0];
    cmd.value       = value;
    if (accept) begin
      unique case (kind)
        REQ_CLEAR: begin
          elem_count_next = '0;
        end
        REQ_INSERT: begin
          priority if (ins_bad) begin
            sts_next = STS_BADPOS;
          end else if (is_full) begin
            sts_next = STS_FULL;
          end else begin
            cmd.ins         = 1'b1;
            elem_count_next = elem_count + CNT_W'(1);
          end
        end
        REQ_DELETE: begin
          priority if (is_empty) begin
            sts_next = STS_EMPTY;
          end else if (rd_bad) begin
            sts_next = STS_BADPOS;
          end else begin
            cmd.del         = 1'b1;
            want_next       = 1'b1;
            elem_count_next = elem_count - CNT_W'(1);
          end
        end
        REQ_READ: begin
          priority if (is_empty) begin
            sts_next = STS_EMPTY;
          end else if (rd_bad) begin
            sts_next = STS_BADPOS;
          end else begin
            want_next = 1'b1;
          end
        end
        default: begin
          sts_next = STS_OK;
        end
      endcase
    end
  end

  // Row of cells; the ends see zero from beyond the row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] left_d, right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cells[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cells[i+1];
    end
    pida_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .my_idx     (IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cells[i])
    );
  end

  // Capture the addressed element before the shift lands
  pida_reduce u_reduce (
    .clk    (clk),
    .load   (accept),
    .idx    (cmd.idx),
    .data   (cells),
    .groups (groups)
  );

  // Final OR across the groups; drop it unless the request returns an element
  always_comb begin
    elem_q_next = '0;
    for (int g = 0; g < NGROUP; g++) begin
      elem_q_next = elem_q_next | groups[g];
    end
    if (!want) begin
      elem_q_next = '0;
    end
  end

  // Next phase
  always_comb begin
    unique case (phase)
      PH_IDLE:   phase_next = start ? PH_GATHER : PH_IDLE;
      PH_GATHER: phase_next = PH_DONE;
      PH_DONE:   phase_next = start ? PH_GATHER : PH_IDLE;
      default:   phase_next = PH_IDLE;
    endcase
  end

  // Phase outputs
  always_comb begin
    busy = (phase == PH_GATHER);
    done = (phase == PH_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      elem_count <= '0;
    end else begin
      phase      <= phase_next;
      elem_count <= elem_count_next;
    end
  end

  // Hold the request's status until its result goes out
  always_ff @(posedge clk) begin
    if (accept) begin
      sts  <= sts_next;
      want <= want_next;
    end
    if (phase == PH_GATHER) begin
      elem_q <= elem_q_next;
    end
  end

  assign status  = sts;
  assign element = elem_q;
  assign count   = cnt_ext[CNT_OUT_W-1:0];

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import pida_pkg::*;

  localparam int TOTAL_REQUESTS = 950;
  localparam int QUIET_TAIL     = 120;   // last requests go out back to back
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with neither a request nor a result
  localparam int SETTLE_CYCLES  = 8;

  // One expected result, as the block should return it
  typedef struct packed {
    status_t              st;
    logic [ELEM_W-1:0]    elem;
    logic [CNT_OUT_W-1:0] cnt;
  } list_result_t;

  // Row of the directed table; the result is only used where typed_in is set
  typedef struct packed {
    req_t             kind;
    logic [POS_W-1:0] pos;
    logic [ELEM_W-1:0] val;
    logic             typed_in;
    list_result_t     res;
  } stim_row_t;

  // Bias of the random request mix
  typedef enum int {
    MIX_GROW,
    MIX_SHRINK,
    MIX_MIXED
  } mix_t;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               req_type;
  logic [POS_W-1:0]         position;
  logic signed [ELEM_W-1:0] value;
  logic                     done;
  logic [1:0]               status;
  logic signed [ELEM_W-1:0] element;
  logic [CNT_OUT_W-1:0]     count;

  // Shadow copy of the list, advanced once per accepted request
  logic [ELEM_W-1:0] list_mem [DEPTH];
  int                list_len;

  list_result_t expected_results [$];
  list_result_t oldest_result;
  int           requests_sent;
  int           mismatches;
  int           quiet_cycles;

  positional_insert_delete_array_top DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req_type (req_type),
    .position (position),
    .value    (value),
    .done     (done),
    .status   (status),
    .element  (element),
    .count    (count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one request to the shadow list and return the result it must give.
  // Checks run in the block's order: insert tests the position before fullness,
  // delete and read test emptiness before the position.
  function automatic list_result_t apply_list_request(req_t kind, logic [POS_W-1:0] pos,
                                                      logic [ELEM_W-1:0] val);
    list_result_t res;
    int           p;
    int           i;
    res.st   = STS_OK;
    res.elem = '0;
    p        = int'(pos);
    case (kind)
      REQ_CLEAR: begin
        // entries are left in place, only the length drops
        list_len = 0;
      end
      REQ_INSERT: begin
        if (p == 0 || p > list_len + 1) begin
          res.st = STS_BADPOS;
        end else if (list_len >= DEPTH) begin
          res.st = STS_FULL;
        end else begin
          for (i = list_len; i >= p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (list_len == 0) begin
          res.st = STS_EMPTY;
        end else if (p == 0 || p > list_len) begin
          res.st = STS_BADPOS;
        end else begin
          res.elem = list_mem[p-1];
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: begin
        if (list_len == 0) begin
          res.st = STS_EMPTY;
        end else if (p == 0 || p > list_len) begin
          res.st = STS_BADPOS;
        end else begin
          res.elem = list_mem[p-1];
        end
      end
    endcase
    res.cnt = list_len[CNT_OUT_W-1:0];
    return res;
  endfunction

  // Random element, weighted towards corner values: the signed extremes, zero and all ones
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly valid positions for the current length, with a share of bad ones
  function automatic logic [POS_W-1:0] pick_position(req_t kind);
    int limit;
    limit = (kind == REQ_INSERT) ? list_len + 1 : list_len;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return POS_W'(limit + 1);
      2:       return POS_W'($urandom_range(0, 127));
      default: begin
        if (limit == 0) return POS_W'($urandom_range(0, 3));
        return POS_W'($urandom_range(1, limit));
      end
    endcase
  endfunction

  function automatic req_t pick_kind(mix_t mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (roll < 1)  return REQ_CLEAR;
        if (roll < 76) return REQ_INSERT;
        if (roll < 84) return REQ_DELETE;
        return REQ_READ;
      end
      MIX_SHRINK: begin
        if (roll < 4)  return REQ_CLEAR;
        if (roll < 20) return REQ_INSERT;
        if (roll < 80) return REQ_DELETE;
        return REQ_READ;
      end
      default: begin
        if (roll < 3)  return REQ_CLEAR;
        if (roll < 43) return REQ_INSERT;
        if (roll < 73) return REQ_DELETE;
        return REQ_READ;
      end
    endcase
  endfunction

  // Present a request and hold it until the block takes it, then log what it
  // must return. Start is left high so a following request can go out back to back.
  task automatic issue_request(input req_t kind, input logic [POS_W-1:0] pos,
                               input logic [ELEM_W-1:0] val, input logic typed_in,
                               input list_result_t typed_res);
    list_result_t res;
    start    <= 1'b1;
    req_type <= kind;
    position <= pos;
    value    <= val;
    do @(posedge clk); while (busy);
    res = apply_list_request(kind, pos, val);
    // a typed-in row overrides the prediction, which still advances the shadow list
    if (typed_in) res = typed_res;
    expected_results.push_back(res);
    requests_sent++;
  endtask

  // Drop start for the number of cycles given
  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and hold off until every outstanding request has been answered
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Random gap after a request, unless idling is off or the run is in its tail
  task automatic maybe_idle(input logic idle_on);
    if (idle_on && requests_sent < TOTAL_REQUESTS - QUIET_TAIL && $urandom_range(0, 4) == 0)
      idle_sender($urandom_range(1, 11));
  endtask

  // Compare each result with the oldest outstanding request
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result returned with no request outstanding");
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (status !== oldest_result.st) begin
          $error("status expected %0d actual %0d", oldest_result.st, status);
          mismatches++;
        end
        if (element !== oldest_result.elem) begin
          $error("element expected %h actual %h", oldest_result.elem, element);
          mismatches++;
        end
        if (count !== oldest_result.cnt) begin
          $error("count expected %0d actual %0d", oldest_result.cnt, count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither a request nor a result moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t directed_rows [20];
    mix_t      mix;
    req_t      kind;
    logic      idle_on;
    int        phase_len;
    int        phase_count;
    int        k;

    rst           <= 1'b1;
    start         <= 1'b0;
    req_type      <= REQ_CLEAR;
    position      <= '0;
    value         <= '0;
    list_len      = 0;
    requests_sent = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    for (k = 0; k < DEPTH; k++) list_mem[k] = '0;

    // Directed table: empty list after reset, bad positions at both ends of the
    // field, signed extremes, shifting on insert and delete, and clear.
    directed_rows[0]  = '{REQ_READ,   7'd1,   32'h0, 1'b1, '{STS_EMPTY,  32'h0, 7'd0}};
    directed_rows[1]  = '{REQ_DELETE, 7'd1,   32'h0, 1'b1, '{STS_EMPTY,  32'h0, 7'd0}};
    directed_rows[2]  = '{REQ_INSERT, 7'd0,   32'h1, 1'b1, '{STS_BADPOS, 32'h0, 7'd0}};
    directed_rows[3]  = '{REQ_INSERT, 7'd2,   32'h1, 1'b1, '{STS_BADPOS, 32'h0, 7'd0}};
    directed_rows[4]  = '{REQ_INSERT, 7'd1,   32'h7FFF_FFFF, 1'b1, '{STS_OK, 32'h0, 7'd1}};
    directed_rows[5]  = '{REQ_INSERT, 7'd1,   32'h8000_0000, 1'b1, '{STS_OK, 32'h0, 7'd2}};
    directed_rows[6]  = '{REQ_INSERT, 7'd3,   32'hFFFF_FFFF, 1'b1, '{STS_OK, 32'h0, 7'd3}};
    directed_rows[7]  = '{REQ_INSERT, 7'd2,   32'h0, 1'b1, '{STS_OK, 32'h0, 7'd4}};
    directed_rows[8]  = '{REQ_READ,   7'd0,   32'h0, 1'b1, '{STS_BADPOS, 32'h0, 7'd4}};
    directed_rows[9]  = '{REQ_READ,   7'd5,   32'h0, 1'b1, '{STS_BADPOS, 32'h0, 7'd4}};
    directed_rows[10] = '{REQ_READ,   7'd127, 32'hFFFF_FFFF, 1'b1, '{STS_BADPOS, 32'h0, 7'd4}};
    directed_rows[11] = '{REQ_READ,   7'd1,   32'h0, 1'b1, '{STS_OK, 32'h8000_0000, 7'd4}};
    directed_rows[12] = '{REQ_READ,   7'd4,   32'h0, 1'b0, '0};
    directed_rows[13] = '{REQ_DELETE, 7'd0,   32'h0, 1'b1, '{STS_BADPOS, 32'h0, 7'd4}};
    directed_rows[14] = '{REQ_DELETE, 7'd5,   32'h0, 1'b1, '{STS_BADPOS, 32'h0, 7'd4}};
    directed_rows[15] = '{REQ_DELETE, 7'd2,   32'h0, 1'b0, '0};
    directed_rows[16] = '{REQ_READ,   7'd2,   32'h0, 1'b0, '0};
    directed_rows[17] = '{REQ_INSERT, 7'd127, 32'h5A5A_A5A5, 1'b1, '{STS_BADPOS, 32'h0, 7'd3}};
    directed_rows[18] = '{REQ_CLEAR,  7'd0,   32'h0, 1'b1, '{STS_OK, 32'h0, 7'd0}};
    directed_rows[19] = '{REQ_READ,   7'd1,   32'h0, 1'b1, '{STS_EMPTY,  32'h0, 7'd0}};

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table, idling now and then so gaps land between requests
    foreach (directed_rows[r]) begin
      issue_request(directed_rows[r].kind, directed_rows[r].pos, directed_rows[r].val,
                    directed_rows[r].typed_in, directed_rows[r].res);
      maybe_idle(1'b1);
    end

    // Fill the list to the brim, then probe fullness and the order of the checks:
    // a bad position on a full list must still report bad position.
    for (k = 0; k < DEPTH; k++) begin
      issue_request(REQ_INSERT, POS_W'($urandom_range(1, list_len + 1)), pick_value(),
                    1'b0, '0);
      maybe_idle(1'b1);
    end
    issue_request(REQ_INSERT, 7'd1, 32'h1234_5678, 1'b1, '{STS_FULL, 32'h0, 7'd64});
    issue_request(REQ_INSERT, 7'd65, 32'h1234_5678, 1'b1, '{STS_FULL, 32'h0, 7'd64});
    issue_request(REQ_INSERT, 7'd66, 32'h1234_5678, 1'b1, '{STS_BADPOS, 32'h0, 7'd64});
    issue_request(REQ_READ, 7'd64, 32'h0, 1'b0, '0);
    issue_request(REQ_READ, 7'd65, 32'h0, 1'b1, '{STS_BADPOS, 32'h0, 7'd64});
    issue_request(REQ_DELETE, 7'd64, 32'h0, 1'b0, '0);
    issue_request(REQ_DELETE, 7'd1, 32'h0, 1'b0, '0);
    drain_results();

    // Random phases: each phase leans towards growing, shrinking or a mix, so the
    // list swings between empty and full many times over the run.
    phase_count = 0;
    while (requests_sent < TOTAL_REQUESTS) begin
      mix       = (phase_count == 0) ? MIX_GROW : mix_t'($urandom_range(0, 2));
      phase_len = (mix == MIX_GROW) ? $urandom_range(100, 180) : $urandom_range(40, 120);
      idle_on   = ($urandom_range(0, 3) != 0);
      for (k = 0; k < phase_len && requests_sent < TOTAL_REQUESTS; k++) begin
        kind = pick_kind(mix);
        issue_request(kind, pick_position(kind), pick_value(), 1'b0, '0);
        maybe_idle(idle_on);
      end
      // hold off between some phases until every request has been answered
      if (phase_count == 0 ||
          (requests_sent < TOTAL_REQUESTS - QUIET_TAIL && $urandom_range(0, 1) == 0))
        drain_results();
      phase_count++;
    end

    // Wait for the last results, then idle for SETTLE_CYCLES to catch any stray strobe
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
